>>> rtl/pcbp_pkg.sv
// Shared types and constants for the path command byte parser.
`default_nettype none

package pcbp_pkg;

   // Command letters in the byte stream
   localparam logic [7:0] CHAR_MOVE  = 8'h4D;  // 'M'
   localparam logic [7:0] CHAR_LINE  = 8'h4C;  // 'L'
   localparam logic [7:0] CHAR_CUBIC = 8'h43;  // 'C'
   localparam logic [7:0] CHAR_CLOSE = 8'h5A;  // 'Z'

   // Operand bookkeeping
   localparam int unsigned OPND_NUM = 6;
   localparam logic [2:0]  OPND_LAST_PAIR  = 3'd1;  // index of the y byte of one pair
   localparam logic [2:0]  OPND_LAST_CUBIC = 3'd5;  // index of the last cubic byte

   // Segment kind codes on the result channel
   localparam logic [1:0] KIND_MOVE  = 2'd0;
   localparam logic [1:0] KIND_LINE  = 2'd1;
   localparam logic [1:0] KIND_CUBIC = 2'd2;
   localparam logic [1:0] KIND_STOP  = 2'd3;

   // Width of the result data bus: every record field but the kind
   localparam int unsigned RSP_WIDTH = 64;

   // Command waiting for operands in the front end
   typedef enum logic [3:0] {
      CMD_NONE  = 4'b0001,
      CMD_MOVE  = 4'b0010,
      CMD_LINE  = 4'b0100,
      CMD_CUBIC = 4'b1000
   } cmd_type;

   // Work handed from the front end to the back end
   typedef enum logic [2:0] {
      OP_NONE  = 3'd0,   // no record, only the end-of-buffer clear
      OP_MOVE  = 3'd1,
      OP_LINE  = 3'd2,
      OP_CUBIC = 3'd3,
      OP_CLOSE = 3'd4,
      OP_STOP  = 3'd5
   } op_type;

   typedef struct packed {
      op_type                          op;
      logic [OPND_NUM-1:0][7:0]        opnd;   // operand bytes, index 0 first
      logic                            clear;  // return points to zero afterwards
   } token_type;

   // One result record
   typedef struct packed {
      logic [7:0] to_y;
      logic [7:0] to_x;
      logic [7:0] ctrl2_y;
      logic [7:0] ctrl2_x;
      logic [7:0] ctrl1_y;
      logic [7:0] ctrl1_x;
      logic [7:0] from_y;
      logic [7:0] from_x;
      logic [1:0] segment_kind;
   } record_type;

endpackage

`default_nettype wire

>>> rtl/path_command_byte_parser.sv
// Top level of the path command byte parser.
// Takes one byte per request ('M' x y, 'L' x y, 'C' x1 y1 x2 y2 x3 y3, 'Z',
// coordinates as raw tenths) and returns one segment record per completed
// command; an unknown command byte returns one stop record and the parser
// ignores bytes until req_tlast, which clears all state after its byte.
// A request is taken every cycle while the two-entry token queue between the
// decoding front end and the point-tracking back end has room; the queue only
// fills while rsp_tready is held low. A completing byte's record is registered
// in the token queue and then in the result register before it is valid on
// the rsp side; the result register lets the next byte enter while it waits.
`default_nettype none

module path_command_byte_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] byte_in
   input  wire logic        req_tlast,   // end_of_buffer
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] from_x, [15:8] from_y, [23:16] ctrl1_x, [31:24] ctrl1_y,
   // [39:32] ctrl2_x, [47:40] ctrl2_y, [55:48] to_x, [63:56] to_y
   output logic [pcbp_pkg::RSP_WIDTH-1:0] rsp_tdata,
   output logic [1:0]       rsp_tuser    // [1:0] segment_kind
);

   logic                 accept;
   logic                 push, pop, q_full, q_valid;
   pcbp_pkg::token_type  push_token, head;
   pcbp_pkg::record_type record;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   pcbp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .byte_in       (req_tdata),
      .end_of_buffer (req_tlast),
      .push          (push),
      .token         (push_token)
   );

   pcbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_token (push_token),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_valid),
      .head       (head)
   );

   pcbp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (head),
      .q_pop      (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_record (record)
   );

   // Pack the record: kind on tuser, points on tdata
   assign rsp_tdata = {record.to_y, record.to_x, record.ctrl2_y, record.ctrl2_x,
                       record.ctrl1_y, record.ctrl1_x, record.from_y, record.from_x};
   assign rsp_tuser = record.segment_kind;

endmodule

`default_nettype wire

>>> rtl/pcbp_front.sv
// Front end: decodes command bytes, gathers operands, issues tokens.
`default_nettype none

module pcbp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,       // request taken this cycle
   input  wire logic [7:0]            byte_in,
   input  wire logic                  end_of_buffer,
   output logic                       push,
   output pcbp_pkg::token_type        token
);

   pcbp_pkg::cmd_type pending_ff, pending_in;
   logic [2:0]        count_ff, count_in;
   logic              halted_ff, halted_in;
   logic [7:0]        opnd_ff [pcbp_pkg::OPND_NUM];
   logic              done;
   logic [2:0]        last_idx;

   // Operand index that completes the pending command
   assign last_idx = (pending_ff == pcbp_pkg::CMD_CUBIC) ? pcbp_pkg::OPND_LAST_CUBIC
                                                         : pcbp_pkg::OPND_LAST_PAIR;
   assign done     = (count_ff == last_idx);

   // Token contents: stored operands with the current byte merged in
   always_comb begin
      token.op    = pcbp_pkg::OP_NONE;
      token.clear = end_of_buffer;
      for (int i = 0; i < pcbp_pkg::OPND_NUM; i++) begin
         token.opnd[i] = (count_ff == 3'(i)) ? byte_in : opnd_ff[i];
      end
      pending_in = pending_ff;
      count_in   = count_ff;
      halted_in  = halted_ff;

      if (!halted_ff) begin
         case (pending_ff)
            pcbp_pkg::CMD_NONE: begin
               count_in = 3'd0;
               case (byte_in)
                  pcbp_pkg::CHAR_MOVE:  pending_in = pcbp_pkg::CMD_MOVE;
                  pcbp_pkg::CHAR_LINE:  pending_in = pcbp_pkg::CMD_LINE;
                  pcbp_pkg::CHAR_CUBIC: pending_in = pcbp_pkg::CMD_CUBIC;
                  pcbp_pkg::CHAR_CLOSE: token.op   = pcbp_pkg::OP_CLOSE;
                  default: begin
                     token.op  = pcbp_pkg::OP_STOP;
                     halted_in = 1'b1;
                  end
               endcase
            end
            pcbp_pkg::CMD_MOVE, pcbp_pkg::CMD_LINE, pcbp_pkg::CMD_CUBIC: begin
               count_in = count_ff + 3'd1;
               if (done) begin
                  pending_in = pcbp_pkg::CMD_NONE;
                  count_in   = 3'd0;
                  if (pending_ff == pcbp_pkg::CMD_MOVE) begin
                     token.op = pcbp_pkg::OP_MOVE;
                  end else if (pending_ff == pcbp_pkg::CMD_LINE) begin
                     token.op = pcbp_pkg::OP_LINE;
                  end else begin
                     token.op = pcbp_pkg::OP_CUBIC;
                  end
               end
            end
            default: begin
               pending_in = pcbp_pkg::CMD_NONE;
               count_in   = 3'd0;
            end
         endcase
      end

      // End of buffer drops any partial command and clears the halt
      if (end_of_buffer) begin
         pending_in = pcbp_pkg::CMD_NONE;
         count_in   = 3'd0;
         halted_in  = 1'b0;
      end
   end

   assign push = accept && ((token.op != pcbp_pkg::OP_NONE) || end_of_buffer);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= pcbp_pkg::CMD_NONE;
         count_ff   <= 3'd0;
         halted_ff  <= 1'b0;
      end else if (accept) begin
         pending_ff <= pending_in;
         count_ff   <= count_in;
         halted_ff  <= halted_in;
      end
   end

   // Operand bytes, written at the running count
   always_ff @(posedge clock) begin
      if (accept && !halted_ff && (pending_ff != pcbp_pkg::CMD_NONE)) begin
         opnd_ff[count_ff] <= byte_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/pcbp_queue.sv
// Two-entry token queue between the front end and the back end.
`default_nettype none

module pcbp_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire pcbp_pkg::token_type   push_token,
   input  wire logic                  pop,
   output logic                       full,
   output logic                       not_empty,
   output pcbp_pkg::token_type        head
);

   pcbp_pkg::token_type entry_ff [2];
   logic                wr_ptr_ff, rd_ptr_ff;
   logic [1:0]          fill_ff;

   assign full      = (fill_ff == 2'd2);
   assign not_empty = (fill_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         case ({push, pop})
            2'b10:   fill_ff <= fill_ff + 2'd1;
            2'b01:   fill_ff <= fill_ff - 2'd1;
            default: fill_ff <= fill_ff;
         endcase
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_token;
   end

endmodule

`default_nettype wire

>>> rtl/pcbp_back.sv
// Back end: tracks current and subpath start points, builds result records.
`default_nettype none

module pcbp_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire pcbp_pkg::token_type   q_head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output pcbp_pkg::record_type       rsp_record
);

   logic [7:0]           cur_x_ff, cur_y_ff, start_x_ff, start_y_ff;
   logic [7:0]           cur_x_in, cur_y_in, start_x_in, start_y_in;
   logic                 out_valid_ff;
   pcbp_pkg::record_type out_ff, rec;
   logic                 has_rec;
   logic                 slot_free;

   assign has_rec   = (q_head.op != pcbp_pkg::OP_NONE);
   assign slot_free = !out_valid_ff || rsp_ready;
   assign q_pop     = q_valid && (slot_free || !has_rec);

   // Record and next points for the head token
   always_comb begin
      rec              = '0;
      rec.from_x       = cur_x_ff;
      rec.from_y       = cur_y_ff;
      cur_x_in         = cur_x_ff;
      cur_y_in         = cur_y_ff;
      start_x_in       = start_x_ff;
      start_y_in       = start_y_ff;
      case (q_head.op)
         pcbp_pkg::OP_MOVE: begin
            rec.segment_kind = pcbp_pkg::KIND_MOVE;
            rec.to_x         = q_head.opnd[0];
            rec.to_y         = q_head.opnd[1];
            cur_x_in         = q_head.opnd[0];
            cur_y_in         = q_head.opnd[1];
            start_x_in       = q_head.opnd[0];
            start_y_in       = q_head.opnd[1];
         end
         pcbp_pkg::OP_LINE: begin
            rec.segment_kind = pcbp_pkg::KIND_LINE;
            rec.to_x         = q_head.opnd[0];
            rec.to_y         = q_head.opnd[1];
            cur_x_in         = q_head.opnd[0];
            cur_y_in         = q_head.opnd[1];
         end
         pcbp_pkg::OP_CUBIC: begin
            rec.segment_kind = pcbp_pkg::KIND_CUBIC;
            rec.ctrl1_x      = q_head.opnd[0];
            rec.ctrl1_y      = q_head.opnd[1];
            rec.ctrl2_x      = q_head.opnd[2];
            rec.ctrl2_y      = q_head.opnd[3];
            rec.to_x         = q_head.opnd[4];
            rec.to_y         = q_head.opnd[5];
            cur_x_in         = q_head.opnd[4];
            cur_y_in         = q_head.opnd[5];
         end
         pcbp_pkg::OP_CLOSE: begin
            // line back to the subpath start, current point unchanged
            rec.segment_kind = pcbp_pkg::KIND_LINE;
            rec.to_x         = start_x_ff;
            rec.to_y         = start_y_ff;
         end
         pcbp_pkg::OP_STOP: begin
            rec.segment_kind = pcbp_pkg::KIND_STOP;
         end
         default: begin
            rec.segment_kind = pcbp_pkg::KIND_MOVE;
         end
      endcase
      if (q_head.clear) begin
         cur_x_in   = 8'd0;
         cur_y_in   = 8'd0;
         start_x_in = 8'd0;
         start_y_in = 8'd0;
      end
   end

   // Point registers and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff     <= 8'd0;
         cur_y_ff     <= 8'd0;
         start_x_ff   <= 8'd0;
         start_y_ff   <= 8'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            cur_x_ff   <= cur_x_in;
            cur_y_ff   <= cur_y_in;
            start_x_ff <= start_x_in;
            start_y_ff <= start_y_in;
         end
         if (q_pop && has_rec) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Output record
   always_ff @(posedge clock) begin
      if (q_pop && has_rec) out_ff <= rec;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_record = out_ff;

endmodule

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the path command byte parser with a built-in segment predictor.

module tb;

   localparam int unsigned BYTE_GOAL  = 1650;
   localparam int unsigned STALL_MAX  = 2000;
   localparam int unsigned TAIL_CYCLES = 10;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } stream_byte_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = 8'h00;   // [7:0] byte_in
   logic                 req_tlast = 1'b0;    // end_of_buffer
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // [7:0] from_x, [15:8] from_y, [23:16] ctrl1_x, [31:24] ctrl1_y,
   // [39:32] ctrl2_x, [47:40] ctrl2_y, [55:48] to_x, [63:56] to_y
   logic [pcbp_pkg::RSP_WIDTH-1:0] rsp_tdata;
   logic [1:0]           rsp_tuser;           // [1:0] segment_kind

   stream_byte_type      byte_q[$];      // bytes waiting to be sent
   pcbp_pkg::record_type segment_q[$];   // segments the parser should return

   // Predicted parser state
   pcbp_pkg::cmd_type    pend_cmd;
   int unsigned          opnd_cnt;
   logic [7:0]           opnd[pcbp_pkg::OPND_NUM];
   logic [7:0]           cur_x, cur_y, start_x, start_y;
   logic                 halted_st;

   int unsigned          taken_cnt = 0;
   int unsigned          err_cnt = 0;
   int unsigned          stall_cnt = 0;
   logic                 quiet;
   logic                 req_fire, rsp_fire;
   pcbp_pkg::record_type got_seg, want_seg;

   path_command_byte_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   // no idling on either side for a stretch in the middle of the run
   assign quiet = (taken_cnt >= 700) && (taken_cnt < 1000);

   task automatic clear_parser();
      pend_cmd  = pcbp_pkg::CMD_NONE;
      opnd_cnt  = 0;
      cur_x     = '0;
      cur_y     = '0;
      start_x   = '0;
      start_y   = '0;
      halted_st = 1'b0;
   endtask

   // Advance the predicted parser by one byte; queue the segment it completes
   task automatic parse_byte(input logic [7:0] b, input logic last);
      pcbp_pkg::record_type seg;
      logic                 done;
      int unsigned          need;
      seg = '0;
      seg.from_x = cur_x;
      seg.from_y = cur_y;
      done = 1'b0;
      if (halted_st) begin
         // bytes dropped until the buffer ends
      end else if (pend_cmd == pcbp_pkg::CMD_NONE) begin
         case (b)
            pcbp_pkg::CHAR_MOVE: begin
               pend_cmd = pcbp_pkg::CMD_MOVE;
               opnd_cnt = 0;
            end
            pcbp_pkg::CHAR_LINE: begin
               pend_cmd = pcbp_pkg::CMD_LINE;
               opnd_cnt = 0;
            end
            pcbp_pkg::CHAR_CUBIC: begin
               pend_cmd = pcbp_pkg::CMD_CUBIC;
               opnd_cnt = 0;
            end
            pcbp_pkg::CHAR_CLOSE: begin
               seg.segment_kind = pcbp_pkg::KIND_LINE;
               seg.to_x = start_x;
               seg.to_y = start_y;
               done = 1'b1;
            end
            default: begin
               seg.segment_kind = pcbp_pkg::KIND_STOP;
               done = 1'b1;
               halted_st = 1'b1;
            end
         endcase
      end else begin
         need = (pend_cmd == pcbp_pkg::CMD_CUBIC) ? 6 : 2;
         opnd[opnd_cnt] = b;
         opnd_cnt++;
         if (opnd_cnt == need) begin
            case (pend_cmd)
               pcbp_pkg::CMD_MOVE: begin
                  seg.segment_kind = pcbp_pkg::KIND_MOVE;
                  seg.to_x = opnd[0];
                  seg.to_y = opnd[1];
                  start_x = opnd[0];
                  start_y = opnd[1];
               end
               pcbp_pkg::CMD_LINE: begin
                  seg.segment_kind = pcbp_pkg::KIND_LINE;
                  seg.to_x = opnd[0];
                  seg.to_y = opnd[1];
               end
               default: begin
                  seg.segment_kind = pcbp_pkg::KIND_CUBIC;
                  seg.ctrl1_x = opnd[0];
                  seg.ctrl1_y = opnd[1];
                  seg.ctrl2_x = opnd[2];
                  seg.ctrl2_y = opnd[3];
                  seg.to_x = opnd[4];
                  seg.to_y = opnd[5];
               end
            endcase
            cur_x = seg.to_x;
            cur_y = seg.to_y;
            done = 1'b1;
            pend_cmd = pcbp_pkg::CMD_NONE;
            opnd_cnt = 0;
         end
      end
      if (done)
         segment_q.push_back(seg);
      if (last)
         clear_parser();
   endtask

   function automatic void add_byte(input logic [7:0] b, input logic last);
      stream_byte_type item;
      item.data = b;
      item.last = last;
      byte_q.push_back(item);
   endfunction

   function automatic logic [7:0] unknown_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == pcbp_pkg::CHAR_MOVE || b == pcbp_pkg::CHAR_LINE ||
             b == pcbp_pkg::CHAR_CUBIC || b == pcbp_pkg::CHAR_CLOSE);
      return b;
   endfunction

   // One buffer of mostly well-formed commands, sometimes cut short or broken.
   // Returns the number of bytes the parser actually acts on.
   function automatic int unsigned add_buffer();
      logic [7:0]  buf_q[$];
      int unsigned n_cmd, sel, need, live;
      logic [7:0]  letter;
      n_cmd = $urandom_range(1, 10);
      live = 0;
      for (int i = 0; i < n_cmd; i++) begin
         sel = $urandom_range(99);
         if (sel < 92) begin
            if (sel < 30) begin
               letter = pcbp_pkg::CHAR_MOVE;
               need = 2;
            end else if (sel < 55) begin
               letter = pcbp_pkg::CHAR_LINE;
               need = 2;
            end else if (sel < 80) begin
               letter = pcbp_pkg::CHAR_CUBIC;
               need = 6;
            end else begin
               letter = pcbp_pkg::CHAR_CLOSE;
               need = 0;
            end
            buf_q.push_back(letter);
            for (int k = 0; k < need; k++)
               buf_q.push_back(8'($urandom_range(255)));
            live += need + 1;
         end else begin
            // unknown command: the rest of the buffer is noise
            buf_q.push_back(unknown_byte());
            live++;
            for (int k = $urandom_range(0, 4); k > 0; k--)
               buf_q.push_back(8'($urandom_range(255)));
            break;
         end
      end
      // command cut off by the end of the buffer
      if (sel < 92 && $urandom_range(99) < 15) begin
         if ($urandom_range(1)) begin
            buf_q.push_back(pcbp_pkg::CHAR_CUBIC);
            need = $urandom_range(0, 5);
         end else begin
            buf_q.push_back($urandom_range(1) ? pcbp_pkg::CHAR_MOVE : pcbp_pkg::CHAR_LINE);
            need = $urandom_range(0, 1);
         end
         for (int k = 0; k < need; k++)
            buf_q.push_back(8'($urandom_range(255)));
         live += need + 1;
      end
      foreach (buf_q[i])
         add_byte(buf_q[i], i == buf_q.size() - 1);
      return live;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
         err_cnt++;
      end
   endtask

   // Request driver: hold a byte until taken, then maybe idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         clear_parser();
      end else begin
         if (req_fire) begin
            parse_byte(req_tdata, req_tlast);
            taken_cnt++;
         end
         if (!req_tvalid || req_fire) begin
            if (byte_q.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
               req_tvalid <= 1'b1;
               req_tdata  <= byte_q[0].data;
               req_tlast  <= byte_q[0].last;
               void'(byte_q.pop_front());
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Segment monitor: compare each returned record with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_fire) begin
            got_seg = pcbp_pkg::record_type'({rsp_tdata, rsp_tuser});
            if (segment_q.size() == 0) begin
               $display("%0t: unexpected segment: expected none, got %h %h",
                        $time, rsp_tdata, rsp_tuser);
               err_cnt++;
            end else begin
               want_seg = segment_q.pop_front();
               check_field("segment_kind", 8'(want_seg.segment_kind),
                           8'(got_seg.segment_kind));
               check_field("from_x", want_seg.from_x, got_seg.from_x);
               check_field("from_y", want_seg.from_y, got_seg.from_y);
               check_field("ctrl1_x", want_seg.ctrl1_x, got_seg.ctrl1_x);
               check_field("ctrl1_y", want_seg.ctrl1_y, got_seg.ctrl1_y);
               check_field("ctrl2_x", want_seg.ctrl2_x, got_seg.ctrl2_x);
               check_field("ctrl2_y", want_seg.ctrl2_y, got_seg.ctrl2_y);
               check_field("to_x", want_seg.to_x, got_seg.to_x);
               check_field("to_y", want_seg.to_y, got_seg.to_y);
            end
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 16);
      end
   end

   // Watchdog: too long without any request or segment moving
   always @(posedge clock) begin
      if (reset || req_fire || rsp_fire) begin
         stall_cnt <= 0;
      end else if (stall_cnt >= STALL_MAX) begin
         $display("%0t: no progress for %0d cycles", $time, stall_cnt);
         $display("== FAIL ==");
         $finish;
      end else begin
         stall_cnt <= stall_cnt + 1;
      end
   end

   initial begin
      int unsigned live_cnt;
      live_cnt = 0;

      // Directed: close at origin, extreme coordinates, all commands
      add_byte(pcbp_pkg::CHAR_CLOSE, 1'b0);
      add_byte(pcbp_pkg::CHAR_MOVE, 1'b0);  add_byte(8'd0, 1'b0);   add_byte(8'd0, 1'b0);
      add_byte(pcbp_pkg::CHAR_MOVE, 1'b0);  add_byte(8'd255, 1'b0); add_byte(8'd255, 1'b0);
      add_byte(pcbp_pkg::CHAR_LINE, 1'b0);  add_byte(8'd0, 1'b0);   add_byte(8'd255, 1'b0);
      add_byte(pcbp_pkg::CHAR_CUBIC, 1'b0);
      add_byte(8'd255, 1'b0); add_byte(8'd0, 1'b0);  add_byte(8'd170, 1'b0);
      add_byte(8'd85, 1'b0);  add_byte(8'd1, 1'b0);  add_byte(8'd254, 1'b0);
      // close back to subpath start, then a line completed by the buffer end
      add_byte(pcbp_pkg::CHAR_CLOSE, 1'b0);
      add_byte(pcbp_pkg::CHAR_LINE, 1'b0);  add_byte(8'd128, 1'b0); add_byte(8'd127, 1'b1);
      // close right after a clear, as the last byte
      add_byte(pcbp_pkg::CHAR_CLOSE, 1'b1);
      // cubic cut off by the buffer end
      add_byte(pcbp_pkg::CHAR_CUBIC, 1'b0); add_byte(8'd10, 1'b0);  add_byte(8'd20, 1'b1);
      // unknown command halts; later command letters are ignored
      add_byte(pcbp_pkg::CHAR_MOVE, 1'b0);  add_byte(8'd5, 1'b0);   add_byte(8'd6, 1'b0);
      add_byte(8'h00, 1'b0);  add_byte(pcbp_pkg::CHAR_MOVE, 1'b0);  add_byte(8'hFF, 1'b1);
      // unknown command as the last byte, then a lone command letter
      add_byte(8'hFF, 1'b1);
      add_byte(pcbp_pkg::CHAR_MOVE, 1'b1);

      // Random buffers
      while (live_cnt < BYTE_GOAL)
         live_cnt += add_buffer();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (byte_q.size() != 0 || req_tvalid || segment_q.size() != 0)
         @(posedge clock);
      // leave room for stray records after the last byte is taken
      repeat (TAIL_CYCLES) @(posedge clock);

      if (err_cnt == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
